FILE: rtl/nud_pkg.sv
package nud_pkg;

   // Result kinds as they appear on the response channel.
   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_HEADER  = 2'd1,
      KIND_END     = 2'd2
   } kind_type;

   localparam logic [7:0] BYTE_ZERO = 8'h00;
   localparam logic [7:0] BYTE_ONE  = 8'h01;
   localparam logic [7:0] BYTE_EPB  = 8'h03;

   // Number of results one input byte can cause, and the step counter over them.
   localparam int MAX_RESULTS = 5;
   localparam int STEP_W      = $clog2(MAX_RESULTS);

   // Command handed from the front to the back: held zeros to release,
   // then an optional byte (payload or header), then an optional end marker.
   typedef struct packed {
      logic [1:0] zeros;
      logic       has_byte;
      logic       is_header;
      logic [7:0] data;
      logic       lost;
      logic       has_end;
   } cmd_type;

endpackage

FILE: rtl/nud_if.sv
interface nud_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       stream_end;

   modport source (output valid, output byte_in, output stream_end, input ready);
   modport sink (input valid, input byte_in, input stream_end, output ready);
endinterface

interface nud_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] data_out;
   logic [4:0] unit_type;
   logic       zeros_lost;
   logic       run_last;

   modport source (output valid, output kind, output data_out, output unit_type,
                   output zeros_lost, output run_last, input ready);
   modport sink (input valid, input kind, input data_out, input unit_type,
                 input zeros_lost, input run_last, output ready);
endinterface

FILE: rtl/nud_front.sv
module nud_front
   import nud_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   nud_req_if.sink   req_chan,
   input  logic      queue_full,
   output logic      push,
   output cmd_type   push_cmd
);

   typedef enum logic [1:0] {
      PH_SEARCH = 2'd0,
      PH_HEADER = 2'd1,
      PH_BODY   = 2'd2
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [1:0] zero_run_ff, zero_run_in;
   logic       trunc_ff, trunc_in;
   logic       closed;
   logic       accept;
   logic [7:0] b;
   logic       two_zeros;

   assign b         = req_chan.byte_in;
   assign two_zeros = zero_run_ff[1];
   assign accept    = req_chan.valid && !queue_full;
   assign req_chan.ready = !queue_full;

   always_comb begin
      phase_in    = phase_ff;
      zero_run_in = zero_run_ff;
      trunc_in    = trunc_ff;
      closed      = 1'b0;
      push_cmd    = '0;
      case (phase_ff)
         PH_HEADER: begin
            push_cmd.has_byte  = 1'b1;
            push_cmd.is_header = 1'b1;
            push_cmd.data      = b;
            phase_in    = PH_BODY;
            zero_run_in = 2'd0;
            trunc_in    = 1'b0;
         end
         PH_BODY: begin
            if (b == BYTE_ZERO) begin
               if (zero_run_ff != 2'd3) begin
                  zero_run_in = zero_run_ff + 2'd1;
               end else begin
                  trunc_in = 1'b1;
               end
            end else if (b == BYTE_ONE && two_zeros) begin
               push_cmd.has_end = 1'b1;
               closed      = 1'b1;
               phase_in    = PH_HEADER;
               zero_run_in = 2'd0;
               trunc_in    = 1'b0;
            end else begin
               // An 0x03 after two or more zeros is emulation prevention and is dropped.
               push_cmd.zeros    = zero_run_ff;
               push_cmd.has_byte = !(b == BYTE_EPB && two_zeros);
               push_cmd.data     = b;
               push_cmd.lost     = trunc_ff;
               zero_run_in = 2'd0;
               trunc_in    = 1'b0;
            end
         end
         default: begin
            if (b == BYTE_ONE && two_zeros) begin
               phase_in    = PH_HEADER;
               zero_run_in = 2'd0;
            end else if (b == BYTE_ZERO) begin
               if (zero_run_ff != 2'd3) begin
                  zero_run_in = zero_run_ff + 2'd1;
               end
            end else begin
               zero_run_in = 2'd0;
            end
            trunc_in = 1'b0;
         end
      endcase
      if (req_chan.stream_end) begin
         if (phase_in == PH_BODY && !closed) begin
            push_cmd.has_end = 1'b1;
         end
         phase_in    = PH_SEARCH;
         zero_run_in = 2'd0;
         trunc_in    = 1'b0;
      end
   end

   assign push = accept && (push_cmd.zeros != 2'd0 || push_cmd.has_byte || push_cmd.has_end);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_SEARCH;
         zero_run_ff <= 2'd0;
         trunc_ff    <= 1'b0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         zero_run_ff <= zero_run_in;
         trunc_ff    <= trunc_in;
      end
   end

endmodule

FILE: rtl/nud_queue.sv
module nud_queue
   import nud_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_cmd
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   cmd_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue count beyond depth");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("front pushed into a full queue");
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("queue count did not drop on pop");
`endif

endmodule

FILE: rtl/nud_back.sv
module nud_back
   import nud_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      head_valid,
   input  cmd_type   head_cmd,
   output logic      pop,
   nud_rsp_if.source rsp_chan
);

   logic [STEP_W-1:0] step_ff, step_in;
   logic [STEP_W-1:0] zeros_w, total;
   logic              is_last, emit;
   kind_type          kind_in;
   logic [7:0]        data_in;
   logic [4:0]        type_in;
   logic              lost_in;

   logic              rsp_valid_ff, rsp_valid_in;
   kind_type          kind_ff;
   logic [7:0]        data_ff;
   logic [4:0]        type_ff;
   logic              lost_ff;
   logic              last_ff;

   assign zeros_w = STEP_W'(head_cmd.zeros);
   assign total   = zeros_w + STEP_W'(head_cmd.has_byte) + STEP_W'(head_cmd.has_end);
   assign is_last = (step_ff == total - STEP_W'(1));
   assign emit    = head_valid && (!rsp_valid_ff || rsp_chan.ready);
   assign pop     = emit && is_last;

   // Results of one order go out as: held zeros, then the byte, then the end marker.
   always_comb begin
      kind_in = KIND_END;
      data_in = BYTE_ZERO;
      type_in = 5'd0;
      lost_in = 1'b0;
      if (step_ff < zeros_w) begin
         kind_in = KIND_PAYLOAD;
         lost_in = head_cmd.lost;
      end else if (step_ff == zeros_w && head_cmd.has_byte) begin
         data_in = head_cmd.data;
         if (head_cmd.is_header) begin
            kind_in = KIND_HEADER;
            type_in = head_cmd.data[4:0];
         end else begin
            kind_in = KIND_PAYLOAD;
            lost_in = head_cmd.lost;
         end
      end
   end

   always_comb begin
      step_in = step_ff;
      if (emit) begin
         step_in = is_last ? '0 : step_ff + STEP_W'(1);
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff <= kind_in;
         data_ff <= data_in;
         type_ff <= type_in;
         lost_ff <= lost_in;
         last_ff <= is_last;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.kind       = kind_ff;
   assign rsp_chan.data_out   = data_ff;
   assign rsp_chan.unit_type  = type_ff;
   assign rsp_chan.zeros_lost = lost_ff;
   assign rsp_chan.run_last   = last_ff;

`ifndef NO_ASSERTIONS
   a_step_in_order: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> step_ff < total)
      else $error("step counter ran past the order");
   a_step_advance: assert property (@(posedge clock) disable iff (reset)
      (emit && !is_last) |=> (head_valid && step_ff == $past(step_ff) + STEP_W'(1)))
      else $error("order left before its last result");
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (emit && kind_in == KIND_END) |-> is_last)
      else $error("end marker not the last result of its byte");
`endif

endmodule

FILE: rtl/nal_unit_deframer.sv
// NAL unit deframer for an Annex B byte stream.
// req_chan takes one stream byte per item with stream_end marking the final
// byte. rsp_chan gives unit headers (with the 5-bit unit type), payload bytes
// with emulation prevention bytes removed, and end markers; run_last flags the
// last result caused by one input byte. Both channels move an item on a rising
// clock edge where valid and ready are both high.
// A result caused by an accepted byte is registered in the command queue and
// then in the output register before it is visible on rsp_chan.
// Throughput: one byte per cycle while each byte causes at most one result
// and the receiver is ready. A byte that causes k results holds the back end
// until all k have gone out (k is at most five: three held zeros, the byte and
// an end marker); the command queue of QUEUE_DEPTH entries absorbs such
// bursts, and req_chan.ready drops only when it is full. Bytes that cause no
// result never enter the queue.
// When the receiver stalls, the output register holds its item and the queue
// fills; input stalls once the queue is full.
// Reset (synchronous) empties the queue and the output register and puts the
// parser back to searching for the first start code.
module nal_unit_deframer
   import nud_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   nud_req_if.sink   req_chan,
   nud_rsp_if.source rsp_chan
);

   logic    push, queue_full, pop, head_valid;
   cmd_type push_cmd, head_cmd;

   nud_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   nud_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   nud_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import nud_pkg::*;

   localparam int STALL_LIMIT   = 3000;
   localparam int HOLD_CYCLES   = 300;
   localparam int RANDOM_ITEMS  = 48;

   typedef enum logic [1:0] {
      SEEK_START,
      AWAIT_HEADER,
      IN_UNIT
   } parse_state_type;

   typedef struct {
      kind_type   kind;
      logic [7:0] data;
      logic [4:0] unit_type;
      logic       lost;
      logic       last;
   } nal_result_type;

   logic clock;
   logic reset;

   nud_req_if req_chan ();
   nud_rsp_if rsp_chan ();

   nal_unit_deframer i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Mirror of the parser state, advanced once per accepted byte.
   parse_state_type parse_state = SEEK_START;
   logic [1:0]      zeros_held  = 2'd0;
   logic            run_cut     = 1'b0;

   nal_result_type pending_results[$];

   int  tx_idle_pct = 0;
   int  rx_idle_pct = 0;
   bit  hold_request = 1'b0;
   int  bytes_sent = 0;
   int  error_count = 0;
   int  quiet_cycles = 0;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic nal_result_type make_result(kind_type k, logic [7:0] d, logic [4:0] t,
                                                  logic l);
      nal_result_type r;
      r.kind      = k;
      r.data      = d;
      r.unit_type = t;
      r.lost      = l;
      r.last      = 1'b0;
      return r;
   endfunction

   function automatic void deframe_byte(logic [7:0] b, logic e);
      nal_result_type step_q[$];
      bit             closed;
      closed = 1'b0;
      case (parse_state)
         AWAIT_HEADER: begin
            step_q.insert(step_q.size(), make_result(KIND_HEADER, b, b[4:0], 1'b0));
            parse_state = IN_UNIT;
            zeros_held  = 2'd0;
            run_cut     = 1'b0;
         end
         IN_UNIT: begin
            if (b == BYTE_ZERO) begin
               if (zeros_held < 2'd3) zeros_held++;
               else run_cut = 1'b1;
            end else if (b == BYTE_ONE && zeros_held >= 2'd2) begin
               step_q.insert(step_q.size(), make_result(KIND_END, 8'h00, 5'd0, 1'b0));
               closed      = 1'b1;
               parse_state = AWAIT_HEADER;
               zeros_held  = 2'd0;
               run_cut     = 1'b0;
            end else begin
               for (int i = 0; i < zeros_held; i++)
                  step_q.insert(step_q.size(),
                                make_result(KIND_PAYLOAD, BYTE_ZERO, 5'd0, run_cut));
               // An 0x03 after two or more zeros is an emulation prevention byte.
               if (!(b == BYTE_EPB && zeros_held >= 2'd2))
                  step_q.insert(step_q.size(), make_result(KIND_PAYLOAD, b, 5'd0, run_cut));
               zeros_held = 2'd0;
               run_cut    = 1'b0;
            end
         end
         default: begin
            if (b == BYTE_ONE && zeros_held >= 2'd2) begin
               parse_state = AWAIT_HEADER;
               zeros_held  = 2'd0;
            end else if (b == BYTE_ZERO) begin
               if (zeros_held < 2'd3) zeros_held++;
            end else begin
               zeros_held = 2'd0;
            end
            run_cut = 1'b0;
         end
      endcase
      if (e) begin
         if (parse_state == IN_UNIT && !closed)
            step_q.insert(step_q.size(), make_result(KIND_END, 8'h00, 5'd0, 1'b0));
         parse_state = SEEK_START;
         zeros_held  = 2'd0;
         run_cut     = 1'b0;
      end
      foreach (step_q[i]) begin
         step_q[i].last = (i == step_q.size() - 1);
         pending_results.insert(pending_results.size(), step_q[i]);
      end
   endfunction

   task automatic push_byte(input logic [7:0] b, input logic e);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.byte_in    <= b;
      req_chan.stream_end <= e;
      do @(posedge clock); while (!req_chan.ready);
      deframe_byte(b, e);
      bytes_sent++;
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic push_start_code(input bit four_byte);
      if (four_byte) push_byte(BYTE_ZERO, 1'b0);
      push_byte(BYTE_ZERO, 1'b0);
      push_byte(BYTE_ZERO, 1'b0);
      push_byte(BYTE_ONE, 1'b0);
   endtask

   // Hand-picked stream: garbage before sync, kept and removed 0x03, a long
   // zero run ending in an emulation byte, a four-byte start code, stream end
   // on a held zero, and a start code completed by the final byte.
   task automatic test_directed();
      logic [7:0] bytes [$];
      logic       ends  [$];
      bytes = '{8'hFF, 8'h00, 8'h00, 8'h01, 8'h65, 8'h00, 8'h03, 8'h00, 8'h00, 8'h03,
                8'h00, 8'h00, 8'h00, 8'h00, 8'h03, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF,
                8'h80, 8'h00, 8'h00, 8'h00, 8'h01};
      ends  = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
      foreach (bytes[i]) push_byte(bytes[i], ends[i]);
      wait_drained();
   endtask

   function automatic logic [7:0] pick_payload_byte();
      int r;
      r = $urandom_range(99);
      if (r < 35) return BYTE_ZERO;
      if (r < 47) return BYTE_EPB;
      if (r < 53) return BYTE_ONE;
      return 8'($urandom_range(255));
   endfunction

   // Mostly well-formed units with random content, some noise and cut streams.
   task automatic test_random_units(input int n_items);
      int         start_count;
      int         plen;
      int         burst;
      bit         end_here;
      logic [7:0] b;
      start_count = bytes_sent;
      while (bytes_sent - start_count < n_items) begin
         if ($urandom_range(99) < 8) begin
            push_byte(8'($urandom_range(255)), ($urandom_range(7) == 0));
         end else begin
            push_start_code($urandom_range(3) == 0);
            plen     = ($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(6);
            end_here = ($urandom_range(99) < 30);
            push_byte(8'($urandom_range(255)), end_here && plen == 0);
            for (int i = 0; i < plen; i++) begin
               if ($urandom_range(99) < 8) begin
                  burst = $urandom_range(6, 2);
                  repeat (burst) push_byte(BYTE_ZERO, 1'b0);
               end
               b = pick_payload_byte();
               push_byte(b, (end_here && i == plen - 1) || ($urandom_range(99) < 2));
            end
         end
      end
      wait_drained();
   endtask

   // The receiver stops for a long time while bytes keep coming, so the
   // command queue fills and the input side must stall.
   task automatic test_output_stall();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      push_start_code(1'b0);
      push_byte(8'h41, 1'b0);
      hold_request = 1'b1;
      repeat (40) push_byte(8'($urandom_range(255, 4)), 1'b0);
      push_byte(8'h7E, 1'b1);
      wait_drained();
   endtask

   initial begin
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.byte_in    = 8'h00;
      req_chan.stream_end = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      tx_idle_pct = 26;
      rx_idle_pct = 63;
      test_random_units(RANDOM_ITEMS);
      tx_idle_pct = 63;
      rx_idle_pct = 26;
      test_random_units(RANDOM_ITEMS);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      test_random_units(RANDOM_ITEMS);
      test_output_stall();
      repeat (10) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

   // Result side: back-pressure, long hold-off on request, and checking.
   initial begin
      int             hold_left;
      nal_result_type want;
      hold_left      = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            if (pending_results.size() == 0) begin
               $error("unexpected result: kind %0d data %0h", rsp_chan.kind, rsp_chan.data_out);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_chan.kind !== want.kind) begin
                  $error("kind: expected %0d, got %0d", want.kind, rsp_chan.kind);
                  error_count++;
               end
               if (rsp_chan.data_out !== want.data) begin
                  $error("data_out: expected %0h, got %0h", want.data, rsp_chan.data_out);
                  error_count++;
               end
               if (rsp_chan.unit_type !== want.unit_type) begin
                  $error("unit_type: expected %0d, got %0d", want.unit_type,
                         rsp_chan.unit_type);
                  error_count++;
               end
               if (rsp_chan.zeros_lost !== want.lost) begin
                  $error("zeros_lost: expected %0b, got %0b", want.lost, rsp_chan.zeros_lost);
                  error_count++;
               end
               if (rsp_chan.run_last !== want.last) begin
                  $error("run_last: expected %0b, got %0b", want.last, rsp_chan.run_last);
                  error_count++;
               end
            end
         end
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (reset) begin
            rsp_chan.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

endmodule
